>>> rtl/core/pps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the projection profile spread block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int PIXEL_W   = 8;
    localparam int INDEX_W   = 6;
    localparam int SPREAD_W  = 17;
    localparam int FRAC_BITS = 16;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [PIXEL_W-1:0]  INK_THRESHOLD_RESET = 8'd100;
    localparam logic [SPREAD_W-1:0] SPREAD_MAX          = '1;

    // Top level sequencer
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_SWEEP,
        ST_TAIL,
        ST_FINISH
    } pps_state_t;

    // Spread unit sequencer
    typedef enum logic [2:0] {
        SP_IDLE,
        SP_MUL,
        SP_SUB,
        SP_DIV,
        SP_SQRT
    } spr_state_t;

    // Control from the sequencer to one spread unit
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic start;
    } spr_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/pps_pixel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pixel_if
// Pixel channel: one gray pixel of a glyph with its position, valid/ready.
// ----------------------------------------------------------------------------
interface pps_pixel_if;
    import pps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIXEL_W-1:0]   pixel;
    logic [INDEX_W-1:0]   row_index;
    logic [INDEX_W-1:0]   col_index;
    logic                 last_pixel;

    modport source (output valid, pixel, row_index, col_index, last_pixel, input ready);
    modport sink   (input valid, pixel, row_index, col_index, last_pixel, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pps_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_result_if
// Result channel: row and column profile spread of one glyph, valid/ready.
// ----------------------------------------------------------------------------
interface pps_result_if;
    import pps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SPREAD_W-1:0]   row_spread;
    logic [SPREAD_W-1:0]   col_spread;

    modport source (output valid, row_spread, col_spread, input ready);
    modport sink   (input valid, row_spread, col_spread, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> rtl/core/pps_spread.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_spread
// Sums a stream of profile counts, then forms floor(256*sqrt((n*Q-S^2)/n))
// with a bit-serial divider followed by a bit-pair serial square root.
// ----------------------------------------------------------------------------
module pps_spread #(
    parameter int N_MAX = pps_pkg::DEF_MAX_ROWS,
    parameter int H_MAX = pps_pkg::DEF_MAX_COLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pps_pkg::spr_ctrl_t                 ctrl,
    input  logic [$clog2(H_MAX+1)-1:0]         count,
    input  logic [$clog2(N_MAX+1)-1:0]         n,
    output logic                               busy,
    output logic [pps_pkg::SPREAD_W-1:0]       spread
);
    import pps_pkg::*;

    localparam int H_W    = $clog2(H_MAX + 1);
    localparam int N_W    = $clog2(N_MAX + 1);
    localparam int S_W    = $clog2(N_MAX * H_MAX + 1);
    localparam int Q_W    = $clog2(N_MAX * H_MAX * H_MAX + 1);
    localparam int P_W    = N_W + Q_W;
    localparam int X_W    = P_W + FRAC_BITS;
    localparam int R_W    = (X_W + 1) / 2;
    localparam int XE_W   = 2 * R_W;
    localparam int SR_W   = R_W + 2;
    localparam int RX_W   = (R_W > SPREAD_W) ? R_W : SPREAD_W;
    localparam int STEP_W = $clog2(X_W + 1);

    spr_state_t state_reg, state_next;

    logic [STEP_W-1:0]   step_reg;
    logic [S_W-1:0]      s_acc_reg;
    logic [Q_W-1:0]      q_acc_reg;
    logic [P_W-1:0]      nq_reg;
    logic [2*S_W-1:0]    ss_reg;
    logic [N_W-1:0]      rem_reg;
    logic [X_W-1:0]      quo_reg;
    logic [XE_W-1:0]     sx_reg;
    logic [SR_W-1:0]     srem_reg;
    logic [R_W-1:0]      root_reg;
    logic [SPREAD_W-1:0] spread_reg;

    logic [2*H_W-1:0]    cnt_sq;
    logic [P_W-1:0]      nq_prod;
    logic [2*S_W-1:0]    ss_prod;
    logic [P_W-1:0]      dev;
    logic                div_last;
    logic                sqrt_last;

    // divider step
    logic [N_W:0]        d_trial;
    logic                d_ge;
    logic [N_W:0]        d_diff;
    logic [N_W-1:0]      rem_nx;
    logic [X_W-1:0]      quo_nx;

    // square root step
    logic [SR_W+1:0]     s_cat;
    logic [SR_W+1:0]     s_trial;
    logic                s_ge;
    logic [SR_W+1:0]     s_diff;
    logic [SR_W-1:0]     srem_nx;
    logic [R_W-1:0]      root_nx;
    logic [RX_W-1:0]     root_x;

    assign cnt_sq  = count * count;
    assign nq_prod = n * q_acc_reg;
    assign ss_prod = s_acc_reg * s_acc_reg;
    assign dev     = nq_reg - P_W'(ss_reg);

    assign div_last  = (step_reg == STEP_W'(X_W - 1));
    assign sqrt_last = (step_reg == STEP_W'(R_W - 1));

    assign d_trial = {rem_reg, quo_reg[X_W-1]};
    assign d_ge    = (d_trial >= {1'b0, n});
    assign d_diff  = d_trial - {1'b0, n};
    assign rem_nx  = d_ge ? d_diff[N_W-1:0] : d_trial[N_W-1:0];
    assign quo_nx  = {quo_reg[X_W-2:0], d_ge};

    assign s_cat   = {srem_reg, sx_reg[XE_W-1:XE_W-2]};
    assign s_trial = (SR_W + 2)'({root_reg, 2'b01});
    assign s_ge    = (s_cat >= s_trial);
    assign s_diff  = s_cat - s_trial;
    assign srem_nx = s_ge ? s_diff[SR_W-1:0] : s_cat[SR_W-1:0];
    assign root_nx = {root_reg[R_W-2:0], s_ge};
    assign root_x  = RX_W'(root_nx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == SP_DIV && div_last) || state_reg == SP_SUB)
            begin
                step_reg <= '0;
            end
            else if (state_reg == SP_DIV || state_reg == SP_SQRT)
            begin
                step_reg <= STEP_W'(step_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SP_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = SP_MUL;
                end
            end
            SP_MUL:  state_next = SP_SUB;
            SP_SUB:  state_next = SP_DIV;
            SP_DIV:
            begin
                if (div_last)
                begin
                    state_next = SP_SQRT;
                end
            end
            SP_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = SP_IDLE;
                end
            end
            default: state_next = SP_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SP_IDLE:
            begin
                // accumulate even on the cycle that starts the finish
                if (ctrl.clear)
                begin
                    s_acc_reg <= '0;
                    q_acc_reg <= '0;
                end
                else if (ctrl.acc_en)
                begin
                    s_acc_reg <= S_W'(s_acc_reg + S_W'(count));
                    q_acc_reg <= Q_W'(q_acc_reg + Q_W'(cnt_sq));
                end
            end
            SP_MUL:
            begin
                nq_reg <= nq_prod;
                ss_reg <= ss_prod;
            end
            SP_SUB:
            begin
                quo_reg <= {dev, {FRAC_BITS{1'b0}}};
                rem_reg <= '0;
            end
            SP_DIV:
            begin
                rem_reg <= rem_nx;
                quo_reg <= quo_nx;
                if (div_last)
                begin
                    sx_reg   <= XE_W'(quo_nx);
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            SP_SQRT:
            begin
                sx_reg   <= {sx_reg[XE_W-3:0], 2'b00};
                srem_reg <= srem_nx;
                root_reg <= root_nx;
                if (sqrt_last)
                begin
                    spread_reg <= (root_x > RX_W'(SPREAD_MAX)) ? SPREAD_MAX
                                                               : root_x[SPREAD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != SP_IDLE);
    assign spread = spread_reg;
endmodule
`default_nettype wire

>>> rtl/core/projection_profile_spread.sv
`default_nettype none
// ----------------------------------------------------------------------------
// projection_profile_spread
// Ink projection profiles of one glyph kept in two count RAMs; after the
// last pixel the profiles are swept, cleared and reduced to their spread.
//
//   channel   dir  word                                           handshake
//   pixels    in   pixel, row_index, col_index, last_pixel        valid/ready
//   results   out  row_spread, col_spread                         valid/ready
//   cfg       in   ink_threshold (cfg_wdata)                      cfg_we
//
// Pixels are taken one per cycle; each updates a row and a column count
// with a read-modify-write, forwarded when the same entry comes back to back.
// After the last pixel the input stalls through a drain state, a sweep of
// max(MAX_ROWS,MAX_COLS) entries, a tail state, the bit-serial divider and
// square root, and the load of the result into the output register.
// After reset a clearing pass over max(MAX_ROWS,MAX_COLS) entries zeroes the
// RAMs before the first pixel is taken. A waiting result holds in the
// output register; only the next glyph's result load waits for it.
// ----------------------------------------------------------------------------
module projection_profile_spread #(
    parameter int MAX_ROWS = pps_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = pps_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pps_pkg::PIXEL_W-1:0]   cfg_wdata,
    pps_pixel_if.sink                     pixels,
    pps_result_if.source                  results
);
    import pps_pkg::*;

    localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RC_W  = $clog2(MAX_COLS + 1);   // row count, up to MAX_COLS
    localparam int CC_W  = $clog2(MAX_ROWS + 1);   // column count, up to MAX_ROWS
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam int MAX_D = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SW_W  = $clog2(MAX_D + 1);

    pps_state_t state_reg, state_next;

    logic [PIXEL_W-1:0] thr_reg;
    logic [SW_W-1:0]    swp_reg;
    logic               swp_last;
    logic               sweeping;

    logic               fire;
    logic               ink;
    logic               row_ok;
    logic               col_ok;
    logic [INDEX_W:0]   row_p1;
    logic [INDEX_W:0]   col_p1;
    logic [NR_W-1:0]    nr_reg;
    logic [NC_W-1:0]    nc_reg;

    // read-modify-write stage and forwarding
    logic               s1_v_reg;
    logic [RA_W-1:0]    s1_row_reg;
    logic [CA_W-1:0]    s1_col_reg;
    logic               fwd_v_reg;
    logic [RA_W-1:0]    fwd_row_reg;
    logic [CA_W-1:0]    fwd_col_reg;
    logic [RC_W-1:0]    fwd_rcnt_reg;
    logic [CC_W-1:0]    fwd_ccnt_reg;
    logic [RC_W-1:0]    row_cur;
    logic [CC_W-1:0]    col_cur;
    logic [RC_W-1:0]    row_new;
    logic [CC_W-1:0]    col_new;

    // RAM ports
    logic               row_we;
    logic [RA_W-1:0]    row_waddr;
    logic [RA_W-1:0]    row_raddr;
    logic [RC_W-1:0]    row_wdata;
    logic [RC_W-1:0]    row_rdata;
    logic               col_we;
    logic [CA_W-1:0]    col_waddr;
    logic [CA_W-1:0]    col_raddr;
    logic [CC_W-1:0]    col_wdata;
    logic [CC_W-1:0]    col_rdata;

    // spread units
    logic               acc_row_v_reg;
    logic               acc_col_v_reg;
    spr_ctrl_t          row_ctrl;
    spr_ctrl_t          col_ctrl;
    logic               row_busy;
    logic               col_busy;
    logic [SPREAD_W-1:0] row_spread_w;
    logic [SPREAD_W-1:0] col_spread_w;

    // output register
    logic                out_v_reg;
    logic [SPREAD_W-1:0] out_row_reg;
    logic [SPREAD_W-1:0] out_col_reg;
    logic                load;

    assign fire   = pixels.valid && pixels.ready;
    assign ink    = (pixels.pixel > thr_reg);
    assign row_ok = (32'(pixels.row_index) < MAX_ROWS);
    assign col_ok = (32'(pixels.col_index) < MAX_COLS);
    assign row_p1 = {1'b0, pixels.row_index} + 1'b1;
    assign col_p1 = {1'b0, pixels.col_index} + 1'b1;

    assign sweeping = state_reg inside {ST_CLEAR, ST_SWEEP};
    assign swp_last = (swp_reg == SW_W'(MAX_D - 1));

    assign load = (state_reg == ST_FINISH) && !row_busy && !col_busy
                  && (!out_v_reg || results.ready);

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            thr_reg       <= INK_THRESHOLD_RESET;
            swp_reg       <= '0;
            s1_v_reg      <= 1'b0;
            fwd_v_reg     <= 1'b0;
            acc_row_v_reg <= 1'b0;
            acc_col_v_reg <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (sweeping && !swp_last)
            begin
                swp_reg <= SW_W'(swp_reg + 1'b1);
            end
            else
            begin
                swp_reg <= '0;
            end
            s1_v_reg      <= fire && ink && row_ok && col_ok;
            fwd_v_reg     <= s1_v_reg;
            acc_row_v_reg <= (state_reg == ST_SWEEP) && (32'(swp_reg) < 32'(nr_reg));
            acc_col_v_reg <= (state_reg == ST_SWEEP) && (32'(swp_reg) < 32'(nc_reg));
            if (load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (swp_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fire && pixels.last_pixel)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_SWEEP;
            ST_SWEEP:
            begin
                if (swp_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_RUN;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    assign pixels.ready = (state_reg == ST_RUN);

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        s1_row_reg   <= RA_W'(pixels.row_index);
        s1_col_reg   <= CA_W'(pixels.col_index);
        fwd_row_reg  <= s1_row_reg;
        fwd_col_reg  <= s1_col_reg;
        fwd_rcnt_reg <= row_new;
        fwd_ccnt_reg <= col_new;
        if (fire && pixels.last_pixel)
        begin
            // clamp the glyph size to the profile depth
            nr_reg <= (32'(row_p1) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(row_p1);
            nc_reg <= (32'(col_p1) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(col_p1);
        end
        if (load)
        begin
            out_row_reg <= row_spread_w;
            out_col_reg <= col_spread_w;
        end
    end

    // The RAM read of the previous write's edge is stale: take the forwarded count.
    assign row_cur = (fwd_v_reg && fwd_row_reg == s1_row_reg) ? fwd_rcnt_reg : row_rdata;
    assign col_cur = (fwd_v_reg && fwd_col_reg == s1_col_reg) ? fwd_ccnt_reg : col_rdata;
    assign row_new = (row_cur < RC_W'(MAX_COLS)) ? RC_W'(row_cur + 1'b1) : row_cur;
    assign col_new = (col_cur < CC_W'(MAX_ROWS)) ? CC_W'(col_cur + 1'b1) : col_cur;

    always_comb
    begin
        row_raddr = RA_W'(pixels.row_index);
        col_raddr = CA_W'(pixels.col_index);
        row_waddr = s1_row_reg;
        col_waddr = s1_col_reg;
        row_wdata = row_new;
        col_wdata = col_new;
        row_we    = s1_v_reg;
        col_we    = s1_v_reg;
        if (sweeping)
        begin
            // read each entry and zero it behind the read
            row_raddr = RA_W'(swp_reg);
            col_raddr = CA_W'(swp_reg);
            row_waddr = RA_W'(swp_reg);
            col_waddr = CA_W'(swp_reg);
            row_wdata = '0;
            col_wdata = '0;
            row_we    = (32'(swp_reg) < MAX_ROWS);
            col_we    = (32'(swp_reg) < MAX_COLS);
        end
    end

    pps_ram #(
        .WIDTH (RC_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    pps_ram #(
        .WIDTH (CC_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // ---------------------------------------------------------------- spread
    always_comb
    begin
        row_ctrl.clear  = (state_reg == ST_DRAIN);
        row_ctrl.acc_en = acc_row_v_reg;
        row_ctrl.start  = (state_reg == ST_TAIL);
        col_ctrl.clear  = (state_reg == ST_DRAIN);
        col_ctrl.acc_en = acc_col_v_reg;
        col_ctrl.start  = (state_reg == ST_TAIL);
    end

    pps_spread #(
        .N_MAX (MAX_ROWS),
        .H_MAX (MAX_COLS)
    ) u_row_spread (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (row_ctrl),
        .count  (row_rdata),
        .n      (nr_reg),
        .busy   (row_busy),
        .spread (row_spread_w)
    );

    pps_spread #(
        .N_MAX (MAX_COLS),
        .H_MAX (MAX_ROWS)
    ) u_col_spread (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (col_ctrl),
        .count  (col_rdata),
        .n      (nc_reg),
        .busy   (col_busy),
        .spread (col_spread_w)
    );

    assign results.valid      = out_v_reg;
    assign results.row_spread = out_row_reg;
    assign results.col_spread = out_col_reg;

`ifndef SYNTHESIS
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> $past(pixels.valid && pixels.ready && pixels.last_pixel))
        else $error("drain entered without a last pixel");

    a_sweep_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP || state_reg == ST_CLEAR) |-> !s1_v_reg)
        else $error("count update pending during sweep");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg == ST_FINISH && !row_busy && !col_busy))
        else $error("result raised before spreads were done");

    a_row_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (row_wdata <= RC_W'(MAX_COLS)))
        else $error("row count written past saturation");
`endif
endmodule
`default_nettype wire

>>> tb/tb_projection_profile_spread.sv
// ----------------------------------------------------------------------------
// tb_projection_profile_spread
// Streams glyph pixels into the projection profile spread block, tracks the
// row and column ink counts alongside it and checks every row/column spread
// word against the value computed here. The ink threshold is swept between
// phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_projection_profile_spread;
    import pps_pkg::*;

    localparam int ROWS = DEF_MAX_ROWS;
    localparam int COLS = DEF_MAX_COLS;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
        logic               last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic [SPREAD_W-1:0] row_spread;
        logic [SPREAD_W-1:0] col_spread;
    } spread_word_t;

    class glyph_spread_tracker;
        logic [PIXEL_W-1:0] threshold;
        int unsigned        row_counts [ROWS];
        int unsigned        col_counts [COLS];
        spread_word_t       pending_spreads [$];
        int                 mismatches;

        function new();
            threshold  = INK_THRESHOLD_RESET;
            mismatches = 0;
            clear_counts();
        endfunction

        function void clear_counts();
            foreach (row_counts[i]) row_counts[i] = 0;
            foreach (col_counts[i]) col_counts[i] = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function logic [SPREAD_W-1:0] profile_spread(int unsigned counts [64], int unsigned n);
            longint unsigned s;
            longint unsigned q;
            longint unsigned d;
            longint unsigned r;
            s = 0;
            q = 0;
            for (int i = 0; i < n; i++)
            begin
                s += counts[i];
                q += longint'(counts[i]) * counts[i];
            end
            d = longint'(n) * q - s * s;
            r = int_sqrt((d << FRAC_BITS) / n);
            if (r > longint'(SPREAD_MAX))
                r = SPREAD_MAX;
            return r[SPREAD_W-1:0];
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        // Update the profiles with one accepted pixel word; close the glyph on last.
        function void note_pixel(pixel_word_t w);
            int unsigned  nr;
            int unsigned  nc;
            spread_word_t e;
            if (w.pixel > threshold && w.row_index < ROWS && w.col_index < COLS)
            begin
                if (row_counts[w.row_index] < COLS)
                    row_counts[w.row_index]++;
                if (col_counts[w.col_index] < ROWS)
                    col_counts[w.col_index]++;
            end
            if (!w.last_pixel)
                return;
            nr = int'(w.row_index) + 1;
            nc = int'(w.col_index) + 1;
            if (nr > ROWS)
                nr = ROWS;
            if (nc > COLS)
                nc = COLS;
            e.row_spread = profile_spread(row_counts, nr);
            e.col_spread = profile_spread(col_counts, nc);
            pending_spreads = {pending_spreads, e};
            clear_counts();
        endfunction

        task check_spread(spread_word_t got);
            spread_word_t e;
            if (pending_spreads.size() == 0)
            begin
                report($sformatf("unexpected result row=%0d col=%0d",
                                 got.row_spread, got.col_spread));
                return;
            end
            e = pending_spreads.pop_front();
            if (got.row_spread !== e.row_spread)
                report($sformatf("row_spread got %0d exp %0d", got.row_spread, e.row_spread));
            if (got.col_spread !== e.col_spread)
                report($sformatf("col_spread got %0d exp %0d", got.col_spread, e.col_spread));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [PIXEL_W-1:0] cfg_wdata;

    pps_pixel_if  pix_ch ();
    pps_result_if res_ch ();

    projection_profile_spread i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    glyph_spread_tracker tracker;
    logic [PIXEL_W-1:0]  cur_threshold;
    bit                  src_steady;
    int                  random_items;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] p, input logic [5:0] r,
                              input logic [5:0] c, input logic last);
        pixel_word_t w;
        int          gap;
        w   = '{pixel: p, row_index: r, col_index: c, last_pixel: last};
        gap = src_steady ? 0 : int'($urandom_range(0, 17));
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel      <= w.pixel;
        pix_ch.row_index  <= w.row_index;
        pix_ch.col_index  <= w.col_index;
        pix_ch.last_pixel <= w.last_pixel;
        do @(posedge clk); while (!pix_ch.ready);
        tracker.note_pixel(w);
    endtask

    // Gray level clustered around the ink threshold, with the extremes mixed in.
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return cur_threshold;
            3:       return (cur_threshold == 8'hFF) ? 8'hFF : cur_threshold + 8'd1;
            4:       return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic send_raster(input int nrows, input int ncols);
        for (int r = 0; r < nrows; r++)
            for (int c = 0; c < ncols; c++)
                send_pixel(pick_pixel(), 6'(r), 6'(c), (r == nrows - 1) && (c == ncols - 1));
    endtask

    task automatic wait_drained();
        while (tracker.pending_spreads.size() != 0)
            @(posedge clk);
        // hold off for a full sweep and square root
        repeat (160) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] v);
        pix_ch.valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.threshold = v;
        cur_threshold     = v;
    endtask

    task automatic random_phase(input int budget);
        int start_items;
        int nr;
        int nc;
        int n;
        int r;
        int c;
        start_items = random_items;
        while (random_items - start_items < budget)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                15, 16, 17, 18:
                begin
                    // scattered pixels, glyph size taken from a random last pixel
                    n = $urandom_range(0, 20);
                    for (int i = 0; i < n; i++)
                        send_pixel(pick_pixel(), 6'($urandom_range(0, 63)),
                                   6'($urandom_range(0, 63)), 1'b0);
                    send_pixel(pick_pixel(), 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), 1'b1);
                    random_items += n + 1;
                end
                19:
                begin
                    // pile mostly full-scale pixels onto one position, more than a count can hold
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                    n = $urandom_range(65, 72);
                    for (int i = 0; i < n; i++)
                        send_pixel(($urandom_range(0, 7) == 0) ? pick_pixel() : 8'hFF,
                                   6'(r), 6'(c), 1'b0);
                    send_pixel(pick_pixel(), 6'($urandom_range(r, 63)),
                               6'($urandom_range(c, 63)), 1'b1);
                    random_items += n + 1;
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        nr = $urandom_range(1, 64);
                        nc = $urandom_range(1, 2);
                        if ($urandom_range(0, 1))
                        begin
                            n  = nr;
                            nr = nc;
                            nc = n;
                        end
                    end
                    else
                    begin
                        nr = $urandom_range(1, 8);
                        nc = $urandom_range(1, 8);
                    end
                    send_raster(nr, nc);
                    random_items += nr * nc;
                end
            endcase
        end
    endtask

    initial
    begin : result_sink
        spread_word_t got;
        int           stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 17);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.row_spread = res_ch.row_spread;
            got.col_spread = res_ch.col_spread;
            tracker.check_spread(got);
        end
    end

    initial
    begin : stimulus
        logic [7:0] plan [10];
        tracker           = new();
        cur_threshold     = INK_THRESHOLD_RESET;
        src_steady        = 1'b0;
        random_items      = 0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        pix_ch.valid      <= 1'b0;
        pix_ch.pixel      <= '0;
        pix_ch.row_index  <= '0;
        pix_ch.col_index  <= '0;
        pix_ch.last_pixel <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // single-pixel glyphs, inked and blank
        send_pixel(8'hFF, 6'd0, 6'd0, 1'b1);
        send_pixel(8'h00, 6'd0, 6'd0, 1'b1);
        // 2 x 3 glyph straddling the reset threshold
        send_pixel(8'd100, 6'd0, 6'd0, 1'b0);
        send_pixel(8'd101, 6'd0, 6'd1, 1'b0);
        send_pixel(8'hFF,  6'd0, 6'd2, 1'b0);
        send_pixel(8'h00,  6'd1, 6'd0, 1'b0);
        send_pixel(8'd150, 6'd1, 6'd1, 1'b0);
        send_pixel(8'hFF,  6'd1, 6'd2, 1'b1);
        // ink outside a 2 x 2 glyph must not enter its spread
        send_pixel(8'hFF, 6'd10, 6'd40, 1'b0);
        send_pixel(8'hFF, 6'd63, 6'd63, 1'b0);
        send_pixel(8'hFF, 6'd1,  6'd1,  1'b1);
        // full 64 x 64 size given by the last pixel alone, ink in the corners
        send_pixel(8'hFF, 6'd0,  6'd0,  1'b0);
        send_pixel(8'hFF, 6'd63, 6'd0,  1'b0);
        send_pixel(8'hFF, 6'd0,  6'd63, 1'b0);
        send_pixel(8'd200, 6'd63, 6'd63, 1'b1);
        // back to back on one row and column
        src_steady = 1'b1;
        send_raster(1, 5);
        send_raster(5, 1);
        src_steady = 1'b0;

        plan[0] = 8'd0;
        plan[1] = 8'd255;
        plan[2] = 8'd1;
        plan[3] = 8'd254;
        plan[4] = 8'($urandom_range(0, 255));
        plan[5] = 8'($urandom_range(0, 255));
        plan[6] = 8'($urandom_range(0, 255));
        plan[7] = 8'd100;
        plan[8] = 8'($urandom_range(0, 255));
        plan[9] = 8'($urandom_range(0, 255));
        foreach (plan[i])
        begin
            write_threshold(plan[i]);
            random_phase(120);
        end

        pix_ch.valid <= 1'b0;
        wait_drained();
        if (tracker.pending_spreads.size() != 0)
            tracker.report("expected results left over");
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pps_pkg.sv
rtl/core/pps_pixel_if.sv
rtl/core/pps_result_if.sv
rtl/core/pps_ram.sv
rtl/core/pps_spread.sv
rtl/core/projection_profile_spread.sv
tb/tb_projection_profile_spread.sv
